// ===== src/assert_macros.svh =====
// Concurrent assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: property violated");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== src/fspa_pkg.sv =====
package fspa_pkg;

   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned SIZE_W     = 16;
   localparam int unsigned CAP_W      = 9;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned QUO_W      = CAP_W;
   localparam int unsigned DIV_W      = CAP_W + SIZE_W;

   localparam int unsigned SLOTS_DEFAULT     = 256;
   localparam int unsigned ADDR_BITS_DEFAULT = 32;

   localparam logic [ADDR_W-1:0] RESET_BASE  = 32'd4096;
   localparam logic [SIZE_W-1:0] RESET_SIZE  = 16'd16;
   localparam int unsigned       RESET_SLOTS = 256;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACQUIRE = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_CLEAR   = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 3'd0,
      STATUS_EMPTY  = 3'd1,
      STATUS_NULL   = 3'd2,
      STATUS_BAD    = 3'd3,
      STATUS_DOUBLE = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE  = 2'd0,
      CSR_SIZE  = 2'd1,
      CSR_SLOTS = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic       load;
      logic       status_we;
      status_type status_code;
      logic       pop;
      logic       mul;
      logic       add;
      logic       refill;
      logic       div_init;
      logic       div_step;
      logic       scan_init;
      logic       scan_step;
      logic       push;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              null_addr;
      logic              bad_early;
      logic              empty;
      logic              div_last;
      logic              rem_nz;
      logic              full;
      logic              in_base;
      logic              scan_hit;
      logic              scan_end;
   } stat_type;

endpackage

// ===== src/fspa_datapath.sv =====
module fspa_datapath #(
   parameter int unsigned SLOTS     = fspa_pkg::SLOTS_DEFAULT,
   parameter int unsigned ADDR_BITS = fspa_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fspa_pkg::cmd_type                   cmd,
   output fspa_pkg::stat_type                  stat,
   input  logic [fspa_pkg::KIND_W-1:0]         req_kind,
   input  logic [fspa_pkg::ADDR_W-1:0]         req_address,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fspa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fspa_pkg::ADDR_W-1:0]         csr_data,
   output logic                                rsp_strobe,
   output logic [fspa_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fspa_pkg::ADDR_W-1:0]         rsp_object_address,
   output logic [fspa_pkg::CAP_W-1:0]          rsp_used_slots,
   output logic [fspa_pkg::CAP_W-1:0]          rsp_free_slots
);
   import fspa_pkg::*;

   localparam int unsigned IDX_W       = $clog2(SLOTS);
   localparam int unsigned DEPTH_W     = $clog2(SLOTS + 1);
   localparam int unsigned CNT_W       = (DEPTH_W > CAP_W) ? DEPTH_W : CAP_W;
   localparam int unsigned PROD_W      = IDX_W + SIZE_W;
   localparam int unsigned SUM_W       = ADDR_W + 1;
   localparam int unsigned STEP_W      = $clog2(QUO_W);
   localparam int unsigned RESET_DEPTH = (SLOTS < RESET_SLOTS) ? SLOTS : RESET_SLOTS;
   localparam logic [ADDR_W-1:0] OBJ_MASK =
      (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [CAP_W-1:0]   slots_ff, slots_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  offset_ff, offset_in;
   logic               below_ff, below_in;
   logic [DIV_W-1:0]   lim_ff, lim_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [DEPTH_W-1:0] mark_ff, mark_in;
   logic [IDX_W-1:0]   top_ff, top_in;
   logic               ident_ff, ident_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [ADDR_W-1:0]  obj_ff, obj_in;
   status_type         status_ff, status_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   dsr_ff, dsr_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DEPTH_W-1:0] ptr_ff, ptr_in;
   logic               cmpv_ff, cmpv_in;
   logic               strobe_ff, strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]  rsp_obj_ff, rsp_obj_in;
   logic [CAP_W-1:0]   rsp_used_ff, rsp_used_in;
   logic [CAP_W-1:0]   rsp_free_ff, rsp_free_in;
   logic [IDX_W-1:0]   rd_data_ff;

   logic [IDX_W-1:0]   stack_mem [SLOTS];

   logic [CNT_W-1:0]   slots_ext;
   logic [CNT_W-1:0]   cap;
   logic [CNT_W-1:0]   depth_ext;
   logic [CNT_W-1:0]   used_full;
   logic [DEPTH_W-1:0] top;
   logic [IDX_W-1:0]   slot_rel;
   logic [IDX_W-1:0]   slot_acq;
   logic [SUM_W-1:0]   sum;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;

   assign csr_ready = 1'b1;

   assign slots_ext = CNT_W'(slots_ff);
   assign cap       = (slots_ext > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slots_ext;
   assign depth_ext = CNT_W'(depth_ff);
   assign used_full = (cap > depth_ext) ? (cap - depth_ext) : '0;
   assign top       = depth_ff - 1'b1;
   assign slot_rel  = IDX_W'(quo_ff);
   assign slot_acq  = ident_ff ? top_ff : rd_data_ff;
   assign sum       = SUM_W'(base_ff) + SUM_W'(prod_ff);
   assign rd_en     = cmd.pop | (cmd.scan_step & (ptr_ff < depth_ff));
   assign rd_addr   = cmd.pop ? top[IDX_W-1:0] : ptr_ff[IDX_W-1:0];

   assign stat.kind      = kind_ff;
   assign stat.null_addr = (addr_ff == '0);
   assign stat.bad_early = below_ff | (size_ff == '0) | (offset_ff >= ADDR_W'(lim_ff));
   assign stat.empty     = (depth_ff == '0);
   assign stat.div_last  = (step_ff == '0);
   assign stat.rem_nz    = (rem_ff != '0);
   assign stat.full      = (depth_ff >= DEPTH_W'(SLOTS));
   assign stat.in_base   = (DEPTH_W'(slot_rel) < mark_ff);
   assign stat.scan_hit  = cmpv_ff & (rd_data_ff == slot_rel);
   assign stat.scan_end  = ~cmpv_ff & (ptr_ff >= depth_ff);

   always_comb begin
      base_in       = base_ff;
      size_in       = size_ff;
      slots_in      = slots_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      offset_in     = offset_ff;
      below_in      = below_ff;
      lim_in        = DIV_W'(slots_ext > CNT_W'(SLOTS) ? CAP_W'(SLOTS) : slots_ff)
                      * DIV_W'(size_ff);
      depth_in      = depth_ff;
      mark_in       = mark_ff;
      top_in        = top_ff;
      ident_in      = ident_ff;
      prod_in       = prod_ff;
      obj_in        = obj_ff;
      status_in     = status_ff;
      rem_in        = rem_ff;
      dsr_in        = dsr_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      ptr_in        = ptr_ff;
      cmpv_in       = cmpv_ff;
      strobe_in     = cmd.finish;
      rsp_status_in = rsp_status_ff;
      rsp_obj_in    = rsp_obj_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_free_in   = rsp_free_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE:  base_in  = csr_data;
            CSR_SIZE:  size_in  = csr_data[SIZE_W-1:0];
            CSR_SLOTS: slots_in = csr_data[CAP_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         kind_in   = req_kind;
         addr_in   = req_address;
         offset_in = req_address - base_ff;
         below_in  = (req_address < base_ff);
         status_in = STATUS_OK;
         obj_in    = '0;
      end

      if (cmd.status_we) begin
         status_in = cmd.status_code;
      end

      if (cmd.pop) begin
         depth_in = top;
         top_in   = top[IDX_W-1:0];
         ident_in = (top < mark_ff);
         if (top < mark_ff) begin
            mark_in = top;
         end
      end

      if (cmd.mul) begin
         prod_in = PROD_W'(slot_acq) * PROD_W'(size_ff);
      end

      if (cmd.add) begin
         obj_in = sum[ADDR_W-1:0] & OBJ_MASK;
      end

      if (cmd.refill) begin
         depth_in = DEPTH_W'(cap);
         mark_in  = DEPTH_W'(cap);
      end

      if (cmd.div_init) begin
         rem_in  = offset_ff[DIV_W-1:0];
         dsr_in  = DIV_W'(size_ff) << (QUO_W - 1);
         quo_in  = '0;
         step_in = STEP_W'(QUO_W - 1);
      end

      if (cmd.div_step) begin
         if (rem_ff >= dsr_ff) begin
            rem_in = rem_ff - dsr_ff;
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         dsr_in  = dsr_ff >> 1;
         step_in = step_ff - 1'b1;
      end

      if (cmd.scan_init) begin
         ptr_in  = mark_ff;
         cmpv_in = 1'b0;
      end

      if (cmd.scan_step) begin
         if (ptr_ff < depth_ff) begin
            ptr_in  = ptr_ff + 1'b1;
            cmpv_in = 1'b1;
         end else begin
            cmpv_in = 1'b0;
         end
      end

      if (cmd.push) begin
         depth_in = depth_ff + 1'b1;
      end

      if (cmd.finish) begin
         rsp_status_in = status_ff;
         rsp_obj_in    = obj_ff;
         rsp_used_in   = CAP_W'(used_full);
         rsp_free_in   = CAP_W'(depth_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= RESET_BASE;
         size_ff   <= RESET_SIZE;
         slots_ff  <= CAP_W'(RESET_SLOTS);
         depth_ff  <= DEPTH_W'(RESET_DEPTH);
         mark_ff   <= DEPTH_W'(RESET_DEPTH);
         cmpv_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         base_ff   <= base_in;
         size_ff   <= size_in;
         slots_ff  <= slots_in;
         depth_ff  <= depth_in;
         mark_ff   <= mark_in;
         cmpv_ff   <= cmpv_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      offset_ff     <= offset_in;
      below_ff      <= below_in;
      lim_ff        <= lim_in;
      top_ff        <= top_in;
      ident_ff      <= ident_in;
      prod_ff       <= prod_in;
      obj_ff        <= obj_in;
      status_ff     <= status_in;
      rem_ff        <= rem_in;
      dsr_ff        <= dsr_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      ptr_ff        <= ptr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_obj_ff    <= rsp_obj_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // entries below mark_ff read as their own index, entries from mark_ff up live here
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[depth_ff[IDX_W-1:0]] <= slot_rel;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_object_address = rsp_obj_ff;
   assign rsp_used_slots     = rsp_used_ff;
   assign rsp_free_slots     = rsp_free_ff;

endmodule

// ===== src/fspa_ctrl.sv =====
module fspa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  fspa_pkg::stat_type stat,
   output fspa_pkg::cmd_type  cmd
);
   import fspa_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_EXEC    = 9'b000000010,
      S_ACQ_MUL = 9'b000000100,
      S_ACQ_ADD = 9'b000001000,
      S_DIV     = 9'b000010000,
      S_CHECK   = 9'b000100000,
      S_SCAN    = 9'b001000000,
      S_PUSH    = 9'b010000000,
      S_FINISH  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (stat.kind)
               KIND_ACQUIRE: begin
                  if (stat.empty) begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = STATUS_EMPTY;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.pop  = 1'b1;
                     state_in = S_ACQ_MUL;
                  end
               end
               KIND_RELEASE: begin
                  if (stat.null_addr) begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = STATUS_NULL;
                     state_in        = S_FINISH;
                  end else if (stat.bad_early) begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = STATUS_BAD;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.div_init = 1'b1;
                     state_in     = S_DIV;
                  end
               end
               KIND_CLEAR: begin
                  cmd.refill = 1'b1;
                  state_in   = S_FINISH;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_ACQ_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACQ_ADD;
         end
         S_ACQ_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_FINISH;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.rem_nz) begin
               cmd.status_we   = 1'b1;
               cmd.status_code = STATUS_BAD;
               state_in        = S_FINISH;
            end else if (stat.full || stat.in_base) begin
               cmd.status_we   = 1'b1;
               cmd.status_code = STATUS_DOUBLE;
               state_in        = S_FINISH;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_hit) begin
               cmd.status_we   = 1'b1;
               cmd.status_code = STATUS_DOUBLE;
               state_in        = S_FINISH;
            end else if (stat.scan_end) begin
               state_in = S_PUSH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/fixed_slot_pool_allocator.sv =====
// Fixed-slot pool allocator with a stack of free slot indices.
// Command channel: drive req_kind and req_address with start; the word is taken
// at a rising edge where start is high and busy is low. Kind acquire pops a slot
// and returns its address, release checks an address and pushes its slot back,
// clear refills the stack with every managed slot.
// Result channel: rsp_strobe is high for exactly one cycle with the status, the
// object address and the used and free counts; the receiver cannot stall it.
// busy falls in the cycle the result is shown, so the next command is taken at
// the edge that ends it; no new word is taken while a command is in progress.
// Path from the accepting edge to the result: clear, the unused kind, empty,
// null or out-of-range release go straight to the finish state; a successful
// acquire pops, multiplies and adds first; a release runs the 9-step slot-size
// divider and is settled in the check state, or goes on to the double-free scan,
// which reads the N slots pushed back since the stack last held only its initial
// run (a hit ends the scan early) and then pushes. The scan reads one entry a cycle.
// Configuration: csr_valid with csr_index and csr_data writes base address,
// slot size or slot count; csr_ready is always high. Write only while idle.
// Reset: registers take their reset values and the stack reads as 0..capacity-1
// at once, so commands are taken from the first cycle after reset.
`include "assert_macros.svh"

module fixed_slot_pool_allocator #(
   parameter int unsigned SLOTS     = fspa_pkg::SLOTS_DEFAULT,
   parameter int unsigned ADDR_BITS = fspa_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [fspa_pkg::KIND_W-1:0]    req_kind,
   input  logic [fspa_pkg::ADDR_W-1:0]    req_address,
   output logic                           rsp_strobe,
   output logic [fspa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fspa_pkg::ADDR_W-1:0]    rsp_object_address,
   output logic [fspa_pkg::CAP_W-1:0]     rsp_used_slots,
   output logic [fspa_pkg::CAP_W-1:0]     rsp_free_slots,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fspa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fspa_pkg::ADDR_W-1:0]    csr_data
);
   import fspa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   fspa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   fspa_datapath #(
      .SLOTS     (SLOTS),
      .ADDR_BITS (ADDR_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_kind           (req_kind),
      .req_address        (req_address),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_object_address (rsp_object_address),
      .rsp_used_slots     (rsp_used_slots),
      .rsp_free_slots     (rsp_free_slots)
   );

   `ASSERT_PROP(a_accept_busy, clock, reset, start && !busy |=> busy)
   `ASSERT_NEVER(a_strobe_idle, clock, reset, rsp_strobe && busy)
   `ASSERT_PROP(a_addr_only_ok, clock, reset, rsp_strobe && (rsp_status != STATUS_OK) |-> (rsp_object_address == '0))
   `ASSERT_PROP(a_empty_count, clock, reset, rsp_strobe && (rsp_status == STATUS_EMPTY) |-> (rsp_free_slots == '0))

endmodule
